// ----- src/svbt_pkg.sv -----
// shared types and constants for the shared variable bound table
// no dependencies; imported by the top level, the checker and the testbench
`default_nettype none

package svbt_pkg;

    localparam logic [63:0] MIN_I64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_I64 = 64'h7FFF_FFFF_FFFF_FFFF;

    // reset word of a bound pair, upper bound in the high half
    localparam logic [127:0] RESET_PAIR = {MAX_I64, MIN_I64};

    typedef enum logic [2:0] {
        CMD_LOAD     = 3'd0,
        CMD_REPORT   = 3'd1,
        CMD_SYNC     = 3'd2,
        CMD_REGISTER = 3'd3,
        CMD_GET      = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_IGNORED     = 2'd1,
        ST_NO_FREE     = 2'd2,
        ST_UNKNOWN_CON = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RPT_UPD,
        S_SYNC_RD,
        S_SYNC_WR,
        S_REG_RD,
        S_REG_CMP,
        S_REG_FIN,
        S_GET_RD,
        S_GET_EMIT,
        S_GET_FIN,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- src/svbt_req_if.sv -----
// request channel of the bound table: valid, ready and one command word
// no dependencies
`default_nettype none

interface svbt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [5:0]  var_index;
    logic [63:0] new_lower;
    logic [63:0] new_upper;
    logic [2:0]  consumer_id;

    modport source (output valid, cmd, var_index, new_lower, new_upper, consumer_id,
                    input ready);
    modport sink (input valid, cmd, var_index, new_lower, new_upper, consumer_id,
                  output ready);
endinterface

`default_nettype wire

// ----- src/svbt_rsp_if.sv -----
// response channel of the bound table: valid, ready and one result word
// no dependencies
`default_nettype none

interface svbt_rsp_if;
    logic        valid;
    logic        ready;
    logic        entry_valid;
    logic [5:0]  out_index;
    logic [63:0] out_lower;
    logic [63:0] out_upper;
    logic        bound_changed;
    logic [2:0]  new_consumer;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, entry_valid, out_index, out_lower, out_upper,
                    bound_changed, new_consumer, status, last,
                    input ready);
    modport sink (input valid, entry_valid, out_index, out_lower, out_upper,
                  bound_changed, new_consumer, status, last,
                  output ready);
endinterface

`default_nettype wire

// ----- src/svbt_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module svbt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [AW-1:0]           waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic                    re,
    input  wire logic [AW-1:0]           raddr,
    output logic      [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

// ----- src/shared_variable_bound_table.sv -----
// top level of the shared variable bound table: sequencer, mark vectors, output register
// depends on svbt_pkg, svbt_req_if, svbt_rsp_if and svbt_ram
//
// Usage: command words arrive on req (valid/ready), result words leave on rsp
// (valid/ready). cfg_we/cfg_wdata write vars_in_use; write it only while idle.
// One command is in work at a time; req.ready is high only in the idle state,
// also while a finished result word still sits in the output register.
// Steps per command, from acceptance to the result word in the output register:
//   load, unknown command, refused commands: dispatch only
//   report: one read of the working copy, then compare and write back
//   synchronize: walk the entries in use, read each dirty one from the working
//   copy and write it to the published copy
//   register consumer: per entry in use, read initial and published pair, then compare
//   get changed: walk the entries in use up to the last marked one, one word per
//   marked entry; a single word when nothing is marked
// The bound pairs sit in three 64-entry rams, one word per variable; a single
// read port per ram sets the one-entry-per-step walk.
// Reset clears marks, consumer count and the per-entry valid bits, so every
// bound reads back as its reset value until written; no clearing pass runs.
// When rsp stalls, the sequencer waits before loading the next result word and
// holds its state until the output register is free.
`default_nettype none

module shared_variable_bound_table
    import svbt_pkg::*;
#(
    parameter int NUM_VARS      = 64,
    parameter int NUM_CONSUMERS = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    svbt_req_if.sink        req,
    svbt_rsp_if.source      rsp,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata
);
    localparam int AW  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int CW  = $clog2(NUM_CONSUMERS + 1);
    localparam int CIW = (NUM_CONSUMERS > 1) ? $clog2(NUM_CONSUMERS) : 1;

    // control state
    state_t                state_reg, state_next;
    logic [6:0]            vars_in_use_reg;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [NUM_VARS-1:0]   dirty_reg, dirty_next;
    logic [NUM_VARS-1:0]   marks_reg [NUM_CONSUMERS];
    logic [NUM_VARS-1:0]   marks_next [NUM_CONSUMERS];
    logic [CW-1:0]         count_reg, count_next;
    logic [NUM_VARS-1:0]   work_vld_reg, work_vld_next;
    logic [NUM_VARS-1:0]   pub_vld_reg, pub_vld_next;
    logic [NUM_VARS-1:0]   init_vld_reg, init_vld_next;
    logic                  out_valid_reg;

    // latched command word and working values
    cmd_t                  cmd_reg;
    logic [5:0]            var_reg;
    logic [63:0]           lo_reg;
    logic [63:0]           hi_reg;
    logic [2:0]            cid_reg;
    logic [NUM_VARS-1:0]   mask_reg, mask_next;
    status_t               status_reg, status_next;
    logic                  chg_reg, chg_next;
    logic [2:0]            cons_reg, cons_next;

    // output word register
    logic                  out_entry_reg;
    logic [5:0]            out_index_reg;
    logic [63:0]           out_lower_reg;
    logic [63:0]           out_upper_reg;
    logic                  out_chg_reg;
    logic [2:0]            out_cons_reg;
    status_t               out_status_reg;
    logic                  out_last_reg;

    // ram ports
    logic                  work_we, work_re, pub_we, pub_re, init_we, init_re;
    logic [AW-1:0]         work_waddr, work_raddr, pub_waddr, pub_raddr;
    logic [AW-1:0]         init_waddr, init_raddr;
    logic [127:0]          work_wdata, pub_wdata, init_wdata;
    logic [127:0]          work_rdata, pub_rdata, init_rdata;

    // result word to load
    logic                  put;
    logic                  put_entry;
    logic [5:0]            put_index;
    logic [63:0]           put_lower;
    logic [63:0]           put_upper;
    logic                  put_chg;
    logic [2:0]            put_cons;
    status_t               put_status;
    logic                  put_last;

    logic                  accept;
    logic                  can_put;
    logic [6:0]            n_use;
    logic                  idx_last;
    logic [AW-1:0]         var_addr;
    logic [AW-1:0]         work_sel;
    logic [CIW-1:0]        cid_idx;
    logic [CIW-1:0]        new_id;
    logic [NUM_VARS-1:0]   cid_marks;
    logic [NUM_VARS-1:0]   later;
    logic                  more;
    logic                  var_bad;
    logic                  cid_bad;
    logic [127:0]          work_pair, pub_pair, init_pair;
    logic                  raise_lo, lower_hi;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign can_put   = !out_valid_reg || rsp.ready;

    // effective count in use
    assign n_use    = (vars_in_use_reg > 7'(NUM_VARS)) ? 7'(NUM_VARS) : vars_in_use_reg;
    assign idx_last = (7'(idx_reg) + 7'd1) == n_use;
    assign var_bad  = {1'b0, var_reg} >= n_use;
    assign var_addr = AW'(var_reg);
    assign cid_idx  = CIW'(cid_reg);
    assign new_id   = CIW'(count_reg);
    assign cid_bad  = (8'(cid_reg) >= 8'(count_reg)) || (8'(cid_reg) >= 8'(NUM_CONSUMERS));
    assign cid_marks = marks_reg[cid_idx];

    // working copy entry in use: the reported variable or the walk index
    assign work_sel = (state_reg == S_RPT_UPD) ? var_addr : idx_reg;

    // ram words, unwritten entries read as their reset pair
    assign work_pair = work_vld_reg[work_sel] ? work_rdata : RESET_PAIR;
    assign pub_pair  = pub_vld_reg[idx_reg] ? pub_rdata : RESET_PAIR;
    assign init_pair = init_vld_reg[idx_reg] ? init_rdata : RESET_PAIR;

    // tightening compares on the working pair
    assign raise_lo = $signed(lo_reg) > $signed(work_pair[63:0]);
    assign lower_hi = $signed(work_pair[127:64]) > $signed(hi_reg);

    // marked entries above the current one that are still in use
    always_comb
    begin
        for (int j = 0; j < NUM_VARS; j++)
        begin
            later[j] = (7'(j) > 7'(idx_reg)) && (7'(j) < n_use);
        end
    end
    assign more = |(cid_marks & later);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer: next state, ram controls and result words
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        chg_next      = chg_reg;
        cons_next     = cons_reg;
        dirty_next    = dirty_reg;
        marks_next    = marks_reg;
        count_next    = count_reg;
        work_vld_next = work_vld_reg;
        pub_vld_next  = pub_vld_reg;
        init_vld_next = init_vld_reg;

        work_we    = 1'b0;
        work_re    = 1'b0;
        work_waddr = var_addr;
        work_raddr = var_addr;
        work_wdata = {hi_reg, lo_reg};
        pub_we     = 1'b0;
        pub_re     = 1'b0;
        pub_waddr  = var_addr;
        pub_raddr  = idx_reg;
        pub_wdata  = {hi_reg, lo_reg};
        init_we    = 1'b0;
        init_re    = 1'b0;
        init_waddr = var_addr;
        init_raddr = idx_reg;
        init_wdata = {hi_reg, lo_reg};

        put        = 1'b0;
        put_entry  = 1'b0;
        put_index  = 6'd0;
        put_lower  = 64'd0;
        put_upper  = 64'd0;
        put_chg    = chg_reg;
        put_cons   = cons_reg;
        put_status = status_reg;
        put_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next    = '0;
                    mask_next   = '0;
                    status_next = ST_OK;
                    chg_next    = 1'b0;
                    cons_next   = 3'd0;
                    state_next  = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                unique case (cmd_reg)
                    CMD_LOAD:
                    begin
                        if (var_bad)
                        begin
                            status_next = ST_IGNORED;
                        end
                        else
                        begin
                            work_we = 1'b1;
                            pub_we  = 1'b1;
                            init_we = 1'b1;
                            work_vld_next[var_addr] = 1'b1;
                            pub_vld_next[var_addr]  = 1'b1;
                            init_vld_next[var_addr] = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    CMD_REPORT:
                    begin
                        if (var_bad)
                        begin
                            status_next = ST_IGNORED;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            work_re    = 1'b1;
                            state_next = S_RPT_UPD;
                        end
                    end
                    CMD_SYNC:
                    begin
                        if (n_use == 7'd0)
                        begin
                            dirty_next = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SYNC_RD;
                        end
                    end
                    CMD_REGISTER:
                    begin
                        if (count_reg >= CW'(NUM_CONSUMERS))
                        begin
                            status_next = ST_NO_FREE;
                            state_next  = S_DONE;
                        end
                        else if (n_use == 7'd0)
                        begin
                            state_next = S_REG_FIN;
                        end
                        else
                        begin
                            state_next = S_REG_RD;
                        end
                    end
                    CMD_GET:
                    begin
                        if (cid_bad)
                        begin
                            status_next = ST_UNKNOWN_CON;
                            state_next  = S_DONE;
                        end
                        else if (n_use == 7'd0)
                        begin
                            state_next = S_GET_FIN;
                        end
                        else
                        begin
                            state_next = S_GET_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // report: tighten the working pair and mark dirty
            S_RPT_UPD:
            begin
                chg_next = raise_lo || lower_hi;
                if (raise_lo || lower_hi)
                begin
                    work_we    = 1'b1;
                    work_wdata = {lower_hi ? hi_reg : work_pair[127:64],
                                  raise_lo ? lo_reg : work_pair[63:0]};
                    work_vld_next[var_addr] = 1'b1;
                    dirty_next[var_addr]    = 1'b1;
                end
                state_next = S_DONE;
            end

            // synchronize walk: skip clean entries, read dirty ones
            S_SYNC_RD:
            begin
                if (dirty_reg[idx_reg])
                begin
                    work_re    = 1'b1;
                    work_raddr = idx_reg;
                    state_next = S_SYNC_WR;
                end
                else if (idx_last)
                begin
                    dirty_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_SYNC_WR:
            begin
                pub_we    = 1'b1;
                pub_waddr = idx_reg;
                pub_wdata = work_pair;
                pub_vld_next[idx_reg] = 1'b1;
                for (int j = 0; j < NUM_CONSUMERS; j++)
                begin
                    if (CW'(j) < count_reg)
                    begin
                        marks_next[j][idx_reg] = 1'b1;
                    end
                end
                if (idx_last)
                begin
                    dirty_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_SYNC_RD;
                end
            end

            // register walk: compare published against initial pair
            S_REG_RD:
            begin
                pub_re     = 1'b1;
                init_re    = 1'b1;
                state_next = S_REG_CMP;
            end

            S_REG_CMP:
            begin
                mask_next[idx_reg] = (pub_pair != init_pair);
                if (idx_last)
                begin
                    state_next = S_REG_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_REG_RD;
                end
            end

            S_REG_FIN:
            begin
                marks_next[new_id] = mask_reg;
                cons_next  = 3'(count_reg);
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            // get walk: one word per marked entry in use
            S_GET_RD:
            begin
                if (cid_marks[idx_reg])
                begin
                    pub_re     = 1'b1;
                    state_next = S_GET_EMIT;
                end
                else if (idx_last)
                begin
                    state_next = S_GET_FIN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_GET_EMIT:
            begin
                if (can_put)
                begin
                    put        = 1'b1;
                    put_entry  = 1'b1;
                    put_index  = 6'(idx_reg);
                    put_lower  = pub_pair[63:0];
                    put_upper  = pub_pair[127:64];
                    put_chg    = 1'b0;
                    put_cons   = 3'd0;
                    put_status = ST_OK;
                    put_last   = !more;
                    if (!more)
                    begin
                        marks_next[cid_idx] = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_GET_RD;
                    end
                end
            end

            // nothing marked: clear and answer with a single word
            S_GET_FIN:
            begin
                marks_next[cid_idx] = '0;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (can_put)
                begin
                    put        = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vars_in_use_reg <= 7'd64;
            dirty_reg       <= '0;
            count_reg       <= '0;
            work_vld_reg    <= '0;
            pub_vld_reg     <= '0;
            init_vld_reg    <= '0;
            out_valid_reg   <= 1'b0;
            idx_reg         <= '0;
            for (int j = 0; j < NUM_CONSUMERS; j++)
            begin
                marks_reg[j] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                vars_in_use_reg <= cfg_wdata;
            end
            dirty_reg    <= dirty_next;
            count_reg    <= count_next;
            work_vld_reg <= work_vld_next;
            pub_vld_reg  <= pub_vld_next;
            init_vld_reg <= init_vld_next;
            idx_reg      <= idx_next;
            marks_reg    <= marks_next;
            if (put)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // command word capture and working values
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(req.cmd);
            var_reg <= req.var_index;
            lo_reg  <= req.new_lower;
            hi_reg  <= req.new_upper;
            cid_reg <= req.consumer_id;
        end
        mask_reg   <= mask_next;
        status_reg <= status_next;
        chg_reg    <= chg_next;
        cons_reg   <= cons_next;
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (put)
        begin
            out_entry_reg  <= put_entry;
            out_index_reg  <= put_index;
            out_lower_reg  <= put_lower;
            out_upper_reg  <= put_upper;
            out_chg_reg    <= put_chg;
            out_cons_reg   <= put_cons;
            out_status_reg <= put_status;
            out_last_reg   <= put_last;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.entry_valid   = out_entry_reg;
    assign rsp.out_index     = out_index_reg;
    assign rsp.out_lower     = out_lower_reg;
    assign rsp.out_upper     = out_upper_reg;
    assign rsp.bound_changed = out_chg_reg;
    assign rsp.new_consumer  = out_cons_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.last          = out_last_reg;

    // working, published and initial bound pairs
    svbt_ram #(.WIDTH(128), .DEPTH(NUM_VARS)) u_work_ram (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .re    (work_re),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    svbt_ram #(.WIDTH(128), .DEPTH(NUM_VARS)) u_pub_ram (
        .clk   (clk),
        .we    (pub_we),
        .waddr (pub_waddr),
        .wdata (pub_wdata),
        .re    (pub_re),
        .raddr (pub_raddr),
        .rdata (pub_rdata)
    );

    svbt_ram #(.WIDTH(128), .DEPTH(NUM_VARS)) u_init_ram (
        .clk   (clk),
        .we    (init_we),
        .waddr (init_waddr),
        .wdata (init_wdata),
        .re    (init_re),
        .raddr (init_raddr),
        .rdata (init_rdata)
    );
endmodule

`default_nettype wire

// ----- sim/bound_table_checker.sv -----
// checker for the shared variable bound table: predicts result words and compares them
// depends on svbt_pkg, svbt_req_if and svbt_rsp_if; instantiated by the testbench top
`default_nettype none

module bound_table_checker
    import svbt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    svbt_req_if             req,
    svbt_rsp_if             rsp,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata,
    output int              mismatches,
    output int              outstanding,
    output int              words_checked,
    output int              entries_seen
);

    localparam int TABLE_SIZE     = 64;
    localparam int CONSUMER_SLOTS = 8;

    typedef struct packed {
        logic        entry_valid;
        logic [5:0]  index;
        logic [63:0] lower;
        logic [63:0] upper;
        logic        changed;
        logic [2:0]  consumer;
        status_t     status;
        logic        last;
    } bound_word_t;

    // own copy of the table
    logic [63:0] work_lo [TABLE_SIZE];
    logic [63:0] work_hi [TABLE_SIZE];
    logic [63:0] pub_lo  [TABLE_SIZE];
    logic [63:0] pub_hi  [TABLE_SIZE];
    logic [63:0] init_lo [TABLE_SIZE];
    logic [63:0] init_hi [TABLE_SIZE];
    logic [63:0] dirty;
    logic [63:0] seen_marks [CONSUMER_SLOTS];
    int          consumers;
    logic [6:0]  vars_cfg;

    bound_word_t result_q[$];
    int          err_count = 0;
    int          word_count = 0;
    int          entry_count = 0;
    int          pend_words;

    assign mismatches    = err_count;
    assign outstanding   = pend_words;
    assign words_checked = word_count;
    assign entries_seen  = entry_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] bound table %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    // append one expected word at the tail
    task automatic queue_word(input bound_word_t item);
        result_q = {result_q, item};
    endtask

    function automatic int in_use();
        return (vars_cfg > 7'd64) ? TABLE_SIZE : int'(vars_cfg);
    endfunction

    // work out the result words of one accepted command word
    task automatic predict_command(input logic [2:0] cmd, input logic [5:0] v,
                                   input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [2:0] cid);
        bound_word_t w;
        bound_word_t prev;
        logic        have_prev;
        logic        rl;
        logic        ru;
        logic [63:0] m;
        int          n;
        n = in_use();
        w = '0;
        w.status = ST_OK;
        w.last = 1'b1;
        have_prev = 1'b0;
        case (cmd)
            CMD_LOAD:
            begin
                if (v >= n)
                    w.status = ST_IGNORED;
                else
                begin
                    init_lo[v] = lo;
                    init_hi[v] = hi;
                    work_lo[v] = lo;
                    work_hi[v] = hi;
                    pub_lo[v]  = lo;
                    pub_hi[v]  = hi;
                end
                queue_word(w);
            end
            CMD_REPORT:
            begin
                if (v >= n)
                    w.status = ST_IGNORED;
                else
                begin
                    // tighten: lower by max, upper by min, signed
                    rl = $signed(lo) > $signed(work_lo[v]);
                    ru = $signed(work_hi[v]) > $signed(hi);
                    if (rl)
                        work_lo[v] = lo;
                    if (ru)
                        work_hi[v] = hi;
                    if (rl || ru)
                        dirty[v] = 1'b1;
                    w.changed = rl || ru;
                end
                queue_word(w);
            end
            CMD_SYNC:
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (dirty[i])
                    begin
                        pub_lo[i] = work_lo[i];
                        pub_hi[i] = work_hi[i];
                        for (int j = 0; j < consumers; j++)
                            seen_marks[j][i] = 1'b1;
                    end
                end
                dirty = '0;
                queue_word(w);
            end
            CMD_REGISTER:
            begin
                if (consumers >= CONSUMER_SLOTS)
                    w.status = ST_NO_FREE;
                else
                begin
                    // new consumer sees every entry that moved since its load
                    m = '0;
                    for (int i = 0; i < n; i++)
                        if (init_lo[i] != pub_lo[i] || init_hi[i] != pub_hi[i])
                            m[i] = 1'b1;
                    seen_marks[consumers] = m;
                    w.consumer = 3'(consumers);
                    consumers++;
                end
                queue_word(w);
            end
            CMD_GET:
            begin
                if (int'(cid) >= consumers)
                begin
                    w.status = ST_UNKNOWN_CON;
                    queue_word(w);
                end
                else
                begin
                    // ascending walk; last mark goes on the final entry
                    for (int i = 0; i < n; i++)
                    begin
                        if (seen_marks[cid][i])
                        begin
                            if (have_prev)
                                queue_word(prev);
                            prev = '0;
                            prev.entry_valid = 1'b1;
                            prev.index = 6'(i);
                            prev.lower = pub_lo[i];
                            prev.upper = pub_hi[i];
                            prev.status = ST_OK;
                            have_prev = 1'b1;
                        end
                    end
                    seen_marks[cid] = '0;
                    if (have_prev)
                    begin
                        prev.last = 1'b1;
                        queue_word(prev);
                    end
                    else
                        queue_word(w);
                end
            end
            default:
                queue_word(w);
        endcase
    endtask

    // compare one accepted result word with the oldest expectation
    task automatic check_word();
        bound_word_t got;
        bound_word_t want;
        got.entry_valid = rsp.entry_valid;
        got.index       = rsp.out_index;
        got.lower       = rsp.out_lower;
        got.upper       = rsp.out_upper;
        got.changed     = rsp.bound_changed;
        got.consumer    = rsp.new_consumer;
        got.status      = status_t'(rsp.status);
        got.last        = rsp.last;
        word_count++;
        if (got.entry_valid === 1'b1)
            entry_count++;
        if (result_q.size() == 0)
            report_mismatch("word with nothing expected, index", 64'(got.index), '0);
        else
        begin
            want = result_q.pop_front();
            if (got.entry_valid !== want.entry_valid)
                report_mismatch("entry_valid", 64'(got.entry_valid), 64'(want.entry_valid));
            if (got.index !== want.index)
                report_mismatch("out_index", 64'(got.index), 64'(want.index));
            if (got.lower !== want.lower)
                report_mismatch("out_lower", got.lower, want.lower);
            if (got.upper !== want.upper)
                report_mismatch("out_upper", got.upper, want.upper);
            if (got.changed !== want.changed)
                report_mismatch("bound_changed", 64'(got.changed), 64'(want.changed));
            if (got.consumer !== want.consumer)
                report_mismatch("new_consumer", 64'(got.consumer), 64'(want.consumer));
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.last !== want.last)
                report_mismatch("last", 64'(got.last), 64'(want.last));
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                work_lo[i] = MIN_I64;
                work_hi[i] = MAX_I64;
                pub_lo[i]  = MIN_I64;
                pub_hi[i]  = MAX_I64;
                init_lo[i] = MIN_I64;
                init_hi[i] = MAX_I64;
            end
            for (int j = 0; j < CONSUMER_SLOTS; j++)
                seen_marks[j] = '0;
            dirty = '0;
            consumers = 0;
            vars_cfg = 7'd64;
            result_q.delete();
            pend_words <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_word();
            if (cfg_we)
                vars_cfg = cfg_wdata;
            if (req.valid && req.ready)
                predict_command(req.cmd, req.var_index, req.new_lower, req.new_upper,
                                req.consumer_id);
            pend_words <= result_q.size();
        end
    end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench top for the shared variable bound table: clock, reset, stimulus and verdict
// depends on svbt_pkg, svbt_req_if, svbt_rsp_if, bound_table_checker and the block itself
`default_nettype none

module testbench;
    import svbt_pkg::*;

    // command codes the block does not know
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;

    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SETTLE       = 8;
    localparam int MAX_GAP      = 17;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    svbt_req_if req_ch();
    svbt_rsp_if rsp_ch();

    int   mismatches;
    int   outstanding;
    int   words_checked;
    int   entries_seen;
    logic calm = 1'b0;
    int   live_vars = 64;
    int   regs_sent = 0;
    int   cmds_sent = 0;
    int   quiet_cycles = 0;

    shared_variable_bound_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    bound_table_checker bound_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .entries_seen  (entries_seen)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic logic [63:0] near_zero(input int span);
        longint v;
        v = longint'($urandom_range(0, 2 * span)) - span;
        return v;
    endfunction

    function automatic logic [63:0] any_bound();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] extreme_bound();
        return ($urandom_range(0, 1) == 0) ? MIN_I64 : MAX_I64;
    endfunction

    // rare wild values among well-formed ones
    function automatic logic [63:0] wild_or(input logic [63:0] tame);
        case ($urandom_range(0, 19))
            0:       return any_bound();
            1:       return extreme_bound();
            default: return tame;
        endcase
    endfunction

    // offer one command word and hold it until accepted
    task automatic send_word(input logic [2:0] cmd, input logic [5:0] idx,
                             input logic [63:0] lo, input logic [63:0] hi,
                             input logic [2:0] cid);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= cmd;
        req_ch.var_index   <= idx;
        req_ch.new_lower   <= lo;
        req_ch.new_upper   <= hi;
        req_ch.consumer_id <= cid;
        do @(posedge clk); while (!req_ch.ready);
        cmds_sent++;
        if (cmd == CMD_REGISTER)
            regs_sent++;
    endtask

    // hold off until every expected word has arrived
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic set_vars(input int count);
        wait_idle();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 7'(count);
        @(posedge clk);
        cfg_we    <= 1'b0;
        live_vars = (count > 64) ? 64 : count;
    endtask

    // one random command, mostly well-formed tightening traffic
    task automatic random_command();
        int          pick;
        logic [5:0]  idx;
        logic [2:0]  cid;
        int          known;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            idx = 6'($urandom_range(0, 63));
        else
            idx = 6'($urandom_range(0, live_vars - 1));
        known = (regs_sent > 8) ? 8 : regs_sent;
        if (known > 0 && $urandom_range(0, 7) != 0)
            cid = 3'($urandom_range(0, known - 1));
        else
            cid = 3'($urandom_range(0, 7));
        if (pick < 10)
            send_word(CMD_LOAD, idx, wild_or(near_zero(100) - 300),
                      wild_or(near_zero(100) + 300), cid);
        else if (pick < 55)
            send_word(CMD_REPORT, idx, wild_or(near_zero(250)), wild_or(near_zero(250)), cid);
        else if (pick < 70)
            send_word(CMD_SYNC, idx, any_bound(), any_bound(), cid);
        else if (pick < 74)
            send_word(CMD_REGISTER, idx, any_bound(), any_bound(), cid);
        else if (pick < 94)
            send_word(CMD_GET, idx, any_bound(), any_bound(), cid);
        else
            send_word(3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C)), idx, any_bound(),
                      any_bound(), cid);
    endtask

    // result side: random stalls per word
    initial
    begin : sink_side
        int stall;
        rsp_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        stall = draw_gap();
        forever
        begin
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            stall = draw_gap();
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles, %0d words still expected",
                         QUIET_LIMIT, outstanding);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and verdict
    initial
    begin : source_side
        int phase_vars [5];
        int phase_len  [5];
        phase_vars = '{37, 13, 64, 1, 64};
        phase_len  = '{70, 70, 70, 20, 70};
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.cmd         <= CMD_LOAD;
        req_ch.var_index   <= '0;
        req_ch.new_lower   <= '0;
        req_ch.new_upper   <= '0;
        req_ch.consumer_id <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: refusals, unknown codes, extremes, publish and fetch
        set_vars(64);
        send_word(CMD_GET, 6'd0, '0, '0, 3'd0);
        send_word(CMD_SPARE_A, 6'd63, any_bound(), any_bound(), 3'd7);
        send_word(CMD_SPARE_B, 6'd0, any_bound(), any_bound(), 3'd0);
        send_word(CMD_SPARE_C, 6'd21, any_bound(), any_bound(), 3'd5);
        send_word(CMD_REGISTER, 6'd0, '0, '0, 3'd0);
        send_word(CMD_GET, 6'd0, '0, '0, 3'd0);
        send_word(CMD_LOAD, 6'd0, MAX_I64, MIN_I64, 3'd0);
        send_word(CMD_LOAD, 6'd63, -64'sd5, 64'sd5, 3'd0);
        send_word(CMD_REPORT, 6'd63, -64'sd10, 64'sd10, 3'd0);
        send_word(CMD_REPORT, 6'd63, 64'sd0, 64'sd3, 3'd0);
        send_word(CMD_REPORT, 6'd0, MIN_I64, MAX_I64, 3'd0);
        send_word(CMD_REPORT, 6'd1, MAX_I64, MIN_I64, 3'd0);
        send_word(CMD_SYNC, 6'd0, '0, '0, 3'd0);
        send_word(CMD_REGISTER, 6'd0, '0, '0, 3'd0);
        send_word(CMD_GET, 6'd0, '0, '0, 3'd1);
        send_word(CMD_GET, 6'd0, '0, '0, 3'd0);
        send_word(CMD_GET, 6'd0, '0, '0, 3'd0);
        send_word(CMD_REPORT, 6'd40, 64'sd7, 64'sd9, 3'd0);
        send_word(CMD_SYNC, 6'd0, '0, '0, 3'd0);
        // narrow table: indexes ignored, marks above the count dropped
        set_vars(1);
        send_word(CMD_LOAD, 6'd5, 64'sd1, 64'sd2, 3'd0);
        send_word(CMD_REPORT, 6'd63, 64'sd1, 64'sd2, 3'd0);
        send_word(CMD_GET, 6'd0, '0, '0, 3'd0);
        set_vars(64);
        send_word(CMD_GET, 6'd0, '0, '0, 3'd0);
        send_word(CMD_GET, 6'd0, '0, '0, 3'd1);

        // random phases over several table sizes
        for (int p = 0; p < 5; p++)
        begin
            set_vars(phase_vars[p]);
            calm = (p == 2);
            for (int i = 0; i < phase_len[p]; i++)
            begin
                random_command();
                if (p == 0 && i == 35)
                    wait_idle();
            end
            calm = 1'b0;
        end

        // fill every consumer slot and one more
        while (regs_sent < 9)
            send_word(CMD_REGISTER, 6'($urandom_range(0, 63)), any_bound(), any_bound(),
                      3'($urandom_range(0, 7)));

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d commands at table sizes 64, 1, 37, 13 and 64, %0d registrations",
                 cmds_sent, regs_sent);
        $display("%0d result words checked, %0d of them carried published bounds",
                 words_checked, entries_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
